@@ rtl/octp_pkg.sv @@
// shared types and constants for the octree path relative move block
package octp_pkg;

    localparam int OFS_W = 17;
    localparam int POS_W = 16;
    localparam int LEVEL_W = 5;
    localparam int CODE_W = 3;
    localparam int AXES = 3;

    typedef enum logic [1:0] {
        OP_ROOT = 2'd0,
        OP_DESC = 2'd1,
        OP_ASC  = 2'd2,
        OP_MOVE = 2'd3
    } t_op;

    typedef struct packed {
        logic load;
        logic step;
        logic hit;
    } t_lane_ctl;

endpackage

@@ rtl/octree_path_relative_move.sv @@
// top level: octree descent path with descend, ascend, root and relative move
//
// input channel i_valid/o_ready carries one request: opcode, child halves
// and signed cell offsets. output channel o_valid/i_ready returns one result
// per request: ok flag, level, cell coordinates and child code of the node.
// the path is held as one coordinate register per axis, MAX_DEPTH bits wide.
// root, descend and ascend requests go from accept straight to the final step.
// move requests: offsets are added one bit per cycle in three serial lanes,
// W = max(MAX_DEPTH, 17) + 2 steps, and then go to the final step. the result
// is loaded into the output register from the final step, and a new request
// is taken only once that step is left; the serial adder sets the move time.
// a new request is taken while the previous result waits at the output;
// it then holds in its final step until the output register is free.
// reset puts the path at the root and empties the output register.
module octree_path_relative_move #(
    parameter int MAX_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_opcode,
    input  logic                               i_child_x,
    input  logic                               i_child_y,
    input  logic                               i_child_z,
    input  logic signed [octp_pkg::OFS_W-1:0]  i_offset_x,
    input  logic signed [octp_pkg::OFS_W-1:0]  i_offset_y,
    input  logic signed [octp_pkg::OFS_W-1:0]  i_offset_z,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_ok,
    output logic [octp_pkg::LEVEL_W-1:0]       o_level,
    output logic [octp_pkg::POS_W-1:0]         o_pos_x,
    output logic [octp_pkg::POS_W-1:0]         o_pos_y,
    output logic [octp_pkg::POS_W-1:0]         o_pos_z,
    output logic [octp_pkg::CODE_W-1:0]        o_top_code
);
    import octp_pkg::*;

    localparam int W = ((MAX_DEPTH > OFS_W) ? MAX_DEPTH : OFS_W) + 2;
    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int CNT_W = $clog2(W);
    localparam int CMP_W = (CNT_W > LVL_W) ? CNT_W : LVL_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADD  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                 r_state;
    logic [CNT_W-1:0]       r_cnt;
    t_op                    r_op;
    logic [AXES-1:0]        r_child;
    logic [MAX_DEPTH-1:0]   r_pos [AXES];
    logic [LVL_W-1:0]       r_level;
    logic                   r_ovalid;
    logic                   r_ok;
    logic [LVL_W-1:0]       r_olevel;
    logic [MAX_DEPTH-1:0]   r_opos [AXES];

    logic                   in_fire;
    logic                   out_fire;
    t_lane_ctl              lane_ctl;
    logic signed [OFS_W-1:0] ofs_in [AXES];
    logic [W-1:0]           lane_sum [AXES];
    logic [AXES-1:0]        lane_bad;
    logic                   n_ok;
    logic [LVL_W-1:0]       n_level;
    logic [MAX_DEPTH-1:0]   n_pos [AXES];

    assign o_ready  = (r_state == S_IDLE);
    assign in_fire  = i_valid & o_ready;
    assign out_fire = (r_state == S_FIN) & (~r_ovalid | i_ready);

    assign ofs_in[0] = i_offset_x;
    assign ofs_in[1] = i_offset_y;
    assign ofs_in[2] = i_offset_z;

    always_comb begin
        lane_ctl.load = in_fire;
        lane_ctl.step = (r_state == S_ADD);
        lane_ctl.hit  = CMP_W'(r_cnt) >= CMP_W'(r_level);
    end

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        octp_lane #(.W(W)) u_lane (
            .i_clk (i_clk),
            .i_ctl (lane_ctl),
            .i_pos (W'(r_pos[a])),
            .i_ofs (W'(ofs_in[a])),
            .o_sum (lane_sum[a]),
            .o_bad (lane_bad[a])
        );
    end

    always_comb begin
        n_ok    = 1'b0;
        n_level = r_level;
        for (int a = 0; a < AXES; a++) begin
            n_pos[a] = r_pos[a];
        end
        unique case (r_op)
            OP_ROOT: begin
                n_ok    = 1'b1;
                n_level = '0;
                for (int a = 0; a < AXES; a++) begin
                    n_pos[a] = '0;
                end
            end
            OP_DESC: begin
                if (r_level < LVL_W'(MAX_DEPTH)) begin
                    n_ok    = 1'b1;
                    n_level = r_level + LVL_W'(1);
                    for (int a = 0; a < AXES; a++) begin
                        n_pos[a] = (r_pos[a] << 1) | MAX_DEPTH'(r_child[a]);
                    end
                end
            end
            OP_ASC: begin
                if (r_level != '0) begin
                    n_ok    = 1'b1;
                    n_level = r_level - LVL_W'(1);
                    for (int a = 0; a < AXES; a++) begin
                        n_pos[a] = r_pos[a] >> 1;
                    end
                end
            end
            OP_MOVE: begin
                if (lane_bad == '0) begin
                    n_ok = 1'b1;
                    for (int a = 0; a < AXES; a++) begin
                        n_pos[a] = lane_sum[a][MAX_DEPTH-1:0];
                    end
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_level  <= '0;
            r_ovalid <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_pos[a] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_cnt   <= '0;
                        r_state <= (t_op'(i_opcode) == OP_MOVE) ? S_ADD : S_FIN;
                    end
                end
                S_ADD: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_fire) begin
                        r_state <= S_IDLE;
                        r_level <= n_level;
                        for (int a = 0; a < AXES; a++) begin
                            r_pos[a] <= n_pos[a];
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (out_fire) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= t_op'(i_opcode);
            r_child <= {i_child_z, i_child_y, i_child_x};
        end
        if (out_fire) begin
            r_ok     <= n_ok;
            r_olevel <= n_level;
            for (int a = 0; a < AXES; a++) begin
                r_opos[a] <= n_pos[a];
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_ok       = r_ok;
    assign o_level    = LEVEL_W'(r_olevel);
    assign o_pos_x    = POS_W'(r_opos[0]);
    assign o_pos_y    = POS_W'(r_opos[1]);
    assign o_pos_z    = POS_W'(r_opos[2]);
    assign o_top_code = {r_opos[2][0], r_opos[1][0], r_opos[0][0]};

`ifndef SYNTH
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(MAX_DEPTH))
        else $error("path level beyond maximum depth");

    a_pos_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pos[0] >> r_level) == '0) && ((r_pos[1] >> r_level) == '0) &&
        ((r_pos[2] >> r_level) == '0))
        else $error("path coordinate outside root at current level");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN))
        else $error("result loaded outside final step");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_ready)
        else $error("request taken while previous one in flight");
`endif

endmodule

@@ rtl/octp_lane.sv @@
// one axis of the move: bit-serial add of cell offset and range check
module octp_lane #(
    parameter int W = 19
) (
    input  logic              i_clk,
    input  octp_pkg::t_lane_ctl i_ctl,
    input  logic [W-1:0]      i_pos,
    input  logic [W-1:0]      i_ofs,
    output logic [W-1:0]      o_sum,
    output logic              o_bad
);
    import octp_pkg::*;

    logic [W-1:0] r_acc;
    logic [W-1:0] r_ofs;
    logic         r_cy;
    logic         r_bad;
    logic         n_bit;
    logic         n_cy;

    always_comb begin
        n_bit = r_acc[0] ^ r_ofs[0] ^ r_cy;
        n_cy  = (r_acc[0] & r_ofs[0]) | (r_acc[0] & r_cy) | (r_ofs[0] & r_cy);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc <= i_pos;
            r_ofs <= i_ofs;
            r_cy  <= 1'b0;
            r_bad <= 1'b0;
        end else if (i_ctl.step) begin
            r_acc <= {n_bit, r_acc[W-1:1]};
            r_ofs <= {r_ofs[W-1], r_ofs[W-1:1]};
            r_cy  <= n_cy;
            r_bad <= r_bad | (n_bit & i_ctl.hit);
        end
    end

    assign o_sum = r_acc;
    assign o_bad = r_bad;

endmodule
